// File: rtl/mrhd_pkg.sv
`default_nettype none

package mrhd_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int FRAC_BITS  = 8;

  localparam int LVL_W = FRAC_BITS + 8;
  localparam int SUM_W = ((LVL_W > 16) ? LVL_W : 16) + 2;
  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int CNT_W = $clog2(NUM_MOTORS + 1);

  localparam logic signed [7:0] LEVEL_MAX = 8'sd100;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_STEP     = 2'd1;
  localparam logic [1:0] REG_REVERSE  = 2'd2;

  localparam logic [19:0] INTERVAL_RST = 20'd20000;
  localparam logic [15:0] STEP_RST     = 16'd256;
  localparam logic [3:0]  REVERSE_RST  = 4'd10;

  typedef logic signed [LVL_W-1:0] lvl_t;

  typedef struct packed {
    logic       changed;
    logic [7:0] duty;
    logic       b_high;
    logic       brake;
  } drive_t;

  typedef struct packed {
    logic [1:0] idx;
    logic [7:0] duty;
    logic       b_high;
    logic       brake;
    logic       last;
  } res_t;

  typedef logic [7:0] duty_tbl_t [128];

  // round(a * 255 / 100), saturated
  function automatic duty_tbl_t duty_table();
    duty_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = (((i * 255 + 50) / 100) > 255) ? 8'd255 : 8'((i * 255 + 50) / 100);
    end
    return t;
  endfunction

  localparam duty_tbl_t DUTY_TBL = duty_table();

endpackage

`default_nettype wire

// File: rtl/mrhd_drive_enc.sv
`default_nettype none

module mrhd_drive_enc (
  input  mrhd_pkg::lvl_t   old_lvl_i,
  input  mrhd_pkg::lvl_t   new_lvl_i,
  input  logic             inv_i,
  output mrhd_pkg::drive_t drive_o
);
  import mrhd_pkg::*;

  // round half away from zero to a signed integer level
  function automatic logic signed [7:0] round_lvl(lvl_t x);
    logic [LVL_W-1:0] mag;
    logic [LVL_W-1:0] sum;
    logic [6:0]       r;
    mag = (x < 0) ? LVL_W'(-x) : LVL_W'(x);
    sum = mag + LVL_W'(1 << (FRAC_BITS - 1));
    r   = 7'(sum >> FRAC_BITS);
    return (x < 0) ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  logic signed [7:0] v_old;
  logic signed [7:0] v_new;
  logic [6:0]        mag_new;
  logic [7:0]        duty_raw;
  logic              rev;

  assign v_old    = round_lvl(old_lvl_i);
  assign v_new    = round_lvl(new_lvl_i);
  assign mag_new  = (v_new < 0) ? 7'(-v_new) : 7'(v_new);
  assign duty_raw = DUTY_TBL[mag_new];
  assign rev      = (v_new < 0) ^ inv_i;

  always_comb begin
    drive_o.changed = (v_new != v_old);
    if (v_new == 8'sd0) begin
      drive_o.duty   = 8'd255;
      drive_o.b_high = 1'b1;
      drive_o.brake  = 1'b1;
    end else if (rev) begin
      drive_o.duty   = 8'd255 - duty_raw;
      drive_o.b_high = 1'b1;
      drive_o.brake  = 1'b0;
    end else begin
      drive_o.duty   = duty_raw;
      drive_o.b_high = 1'b0;
      drive_o.brake  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/motor_ramp_hbridge_drive.sv
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   operation, motor_index, target, elapsed_us
// out       output     out_valid_o / out_ready_i motor_index_res, line_a_duty, line_b_high,
//                                                brake, last
// apb       input      psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// a set transfer and a tick below the interval leave the block idle and ready
// a tick that updates reads the level memories one channel a cycle unless the
// output stalls, with write-back from the calc stage one channel behind the read
// a stalled output holds the channel pipeline only when a new result and the
// held result both wait for the output register
// reset clears the control and config registers and the entry valid bits; no memory clearing pass

module motor_ramp_hbridge_drive (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [1:0]  motor_index_i,
  input  logic signed [7:0] target_i,
  input  logic [15:0] elapsed_us_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  motor_index_res_o,
  output logic [7:0]  line_a_duty_o,
  output logic        line_b_high_o,
  output logic        brake_o,
  output logic        last_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrhd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [19:0] interval_q;
  logic [15:0] step_q;
  logic [3:0]  rmask_q;
  logic [31:0] acc_q;

  logic signed [7:0] tgt_mem [NUM_MOTORS];
  lvl_t              act_mem [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] tgt_vld_q;
  logic [NUM_MOTORS-1:0] act_vld_q;
  logic signed [7:0] rd_tgt_q;
  lvl_t              rd_act_q;
  logic              rd_tvld_q;
  logic              rd_avld_q;

  logic [CNT_W-1:0] rd_cnt_q;
  logic             calc_v_q;
  logic [IDX_W-1:0] calc_idx_q;
  logic             pend_v_q;
  res_t             pend_q;
  logic             out_v_q;
  res_t             out_q;

  logic              in_xfer;
  logic              cfg_wr;
  logic [31:0]       acc_sum;
  logic              tick_hit;
  logic              set_we;
  logic signed [7:0] tgt_sat;
  logic [IDX_W-1:0]  rd_idx;
  logic signed [7:0] tgt_cur;
  lvl_t              act_cur;
  logic signed [SUM_W-1:0] old_x;
  logic signed [SUM_W-1:0] tgt_x;
  logic signed [SUM_W-1:0] step_x;
  logic signed [SUM_W-1:0] up_x;
  logic signed [SUM_W-1:0] dn_x;
  logic signed [SUM_W-1:0] nv_x;
  lvl_t              new_lvl;
  drive_t            drv;
  logic              new_res;
  logic              out_free;
  logic              stall;
  logic              advance;
  logic              rd_en;
  logic              wr_en;
  logic              push_pend;
  logic              flush_out;

  // apb registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_INTERVAL: prdata = 32'(interval_q);
      REG_STEP:     prdata = 32'(step_q);
      REG_REVERSE:  prdata = 32'(rmask_q);
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      step_q     <= STEP_RST;
      rmask_q    <= REVERSE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INTERVAL: interval_q <= pwdata[19:0];
        REG_STEP:     step_q     <= pwdata[15:0];
        REG_REVERSE:  rmask_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign acc_sum    = acc_q + 32'(elapsed_us_i);
  assign tick_hit   = (acc_sum >= 32'(interval_q));
  assign set_we     = in_xfer && (operation_i == OP_SET)
                      && (32'(motor_index_i) < 32'(NUM_MOTORS));
  assign tgt_sat    = (target_i > LEVEL_MAX) ? LEVEL_MAX :
                      (target_i < -LEVEL_MAX) ? -LEVEL_MAX : target_i;

  // ramp datapath on the registered read data
  assign rd_idx  = rd_cnt_q[IDX_W-1:0];
  assign tgt_cur = rd_tvld_q ? rd_tgt_q : 8'sd0;
  assign act_cur = rd_avld_q ? rd_act_q : lvl_t'(0);
  assign old_x   = SUM_W'(act_cur);
  assign tgt_x   = SUM_W'(tgt_cur) <<< FRAC_BITS;
  assign step_x  = $signed(SUM_W'(step_q));
  assign up_x    = old_x + step_x;
  assign dn_x    = old_x - step_x;

  always_comb begin
    if (tgt_x == old_x) begin
      nv_x = old_x;
    end else if (tgt_x > old_x) begin
      nv_x = (up_x > tgt_x) ? tgt_x : up_x;
    end else begin
      nv_x = (dn_x < tgt_x) ? tgt_x : dn_x;
    end
  end

  assign new_lvl = LVL_W'(nv_x);

  mrhd_drive_enc u_enc (
    .old_lvl_i (act_cur),
    .new_lvl_i (new_lvl),
    .inv_i     (rmask_q[calc_idx_q]),
    .drive_o   (drv)
  );

  // sequencing
  assign new_res   = calc_v_q && drv.changed;
  assign out_free  = !out_v_q || out_ready_i;
  assign stall     = new_res && pend_v_q && !out_free;
  assign advance   = (state_q == ST_RUN) && !stall;
  assign rd_en     = advance && (rd_cnt_q < CNT_W'(NUM_MOTORS));
  assign wr_en     = advance && calc_v_q;
  assign push_pend = advance && new_res && pend_v_q;
  assign flush_out = (state_q == ST_FLUSH) && pend_v_q && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (operation_i == OP_TICK) && tick_hit) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && !calc_v_q && (rd_cnt_q == CNT_W'(NUM_MOTORS))) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || flush_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      acc_q      <= 32'd0;
      rd_cnt_q   <= '0;
      calc_v_q   <= 1'b0;
      calc_idx_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      tgt_vld_q  <= '0;
      act_vld_q  <= '0;
      rd_tvld_q  <= 1'b0;
      rd_avld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && (operation_i == OP_TICK)) begin
        acc_q <= tick_hit ? 32'd0 : acc_sum;
      end
      if (state_q == ST_IDLE) begin
        rd_cnt_q <= '0;
        calc_v_q <= 1'b0;
      end else if (advance) begin
        calc_v_q   <= rd_en;
        calc_idx_q <= rd_idx;
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CNT_W'(1);
        end
      end
      if (set_we) begin
        tgt_vld_q[IDX_W'(motor_index_i)] <= 1'b1;
      end
      if (wr_en) begin
        act_vld_q[calc_idx_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_tvld_q <= tgt_vld_q[rd_idx];
        rd_avld_q <= act_vld_q[rd_idx];
      end
      if (advance && new_res) begin
        pend_v_q <= 1'b1;
      end else if (flush_out) begin
        pend_v_q <= 1'b0;
      end
      if (push_pend || flush_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // level memories, read-modify-write one channel behind the read
  always_ff @(posedge clk_i) begin
    if (set_we) begin
      tgt_mem[IDX_W'(motor_index_i)] <= tgt_sat;
    end
    if (wr_en) begin
      act_mem[calc_idx_q] <= new_lvl;
    end
    if (rd_en) begin
      rd_tgt_q <= tgt_mem[rd_idx];
      rd_act_q <= act_mem[rd_idx];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && new_res) begin
      pend_q.idx    <= 2'(calc_idx_q);
      pend_q.duty   <= drv.duty;
      pend_q.b_high <= drv.b_high;
      pend_q.brake  <= drv.brake;
      pend_q.last   <= 1'b0;
    end
    if (push_pend || flush_out) begin
      out_q <= '{idx: pend_q.idx, duty: pend_q.duty, b_high: pend_q.b_high,
                 brake: pend_q.brake, last: flush_out};
    end
  end

  assign out_valid_o       = out_v_q;
  assign motor_index_res_o = out_q.idx;
  assign line_a_duty_o     = out_q.duty;
  assign line_b_high_o     = out_q.b_high;
  assign brake_o           = out_q.brake;
  assign last_o            = out_q.last;

`ifndef SYNTH
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("held result left behind at end of tick");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_pend || flush_out) |-> out_free)
    else $error("output register overwritten before transfer");

  a_short_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (operation_i == OP_TICK) && !tick_hit) |=> (state_q == ST_IDLE))
    else $error("tick below interval started an update");

  a_rmw_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_idx != calc_idx_q))
    else $error("read and write-back hit the same entry");

  a_set_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en || wr_en) |-> !set_we)
    else $error("target write during channel sweep");
`endif

endmodule

`default_nettype wire
